// File: hw/rtl/b7s_pkg.sv
// ----------------------------------------------------------------------------
// b7s_pkg: shared types and constants for the seven-segment digit writer
// Digit patterns, polarity handling, command format and status codes.
// ----------------------------------------------------------------------------
package b7s_pkg;

  // number of attached displays and segment pins
  localparam int NUM_DIGITS = 4;
  localparam int SEG_PINS   = 8;

  // width of a display index inside the block
  localparam int DISP_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  // command queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // pins that exist on the display
  localparam logic [7:0] PIN_MASK = 8'((16'd1 << SEG_PINS) - 16'd1);

  // divide by ten: exact for every 16-bit value
  localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
  localparam int          DIV10_SHIFT = 19;

  // largest digit value
  localparam logic [15:0] MAX_DIGIT = 16'd9;

  // ten to the power of n, used at elaboration only
  function automatic int unsigned pow10(input int n);
    int unsigned r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = r * 10;
    end
    return r;
  endfunction

  // numbers at or above this need more digits than there are displays
  localparam int unsigned DEC_LIMIT = pow10(NUM_DIGITS);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_BAD_VALUE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_SINGLE   = 2'd0,
    KIND_NUMBER   = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_t;

  typedef enum logic {
    OP_DIGIT  = 1'b0,
    OP_NUMBER = 1'b1
  } op_t;

  // classified request handed from front to back
  typedef struct packed {
    kind_t              kind;
    logic [DISP_W-1:0]  disp;
    logic [15:0]        value;
    logic               we;
    status_t            status;
  } cmd_t;

  // common-anode pattern of one decimal digit
  function automatic logic [7:0] digit_pattern(input logic [3:0] d);
    logic [7:0] p;
    unique case (d)
      4'd0:    p = 8'hC0;
      4'd1:    p = 8'hF9;
      4'd2:    p = 8'hA4;
      4'd3:    p = 8'hB0;
      4'd4:    p = 8'h99;
      4'd5:    p = 8'h92;
      4'd6:    p = 8'h82;
      4'd7:    p = 8'hF8;
      4'd8:    p = 8'h80;
      4'd9:    p = 8'h90;
      default: p = 8'hC0;
    endcase
    return p;
  endfunction

  // pattern with polarity of the display applied
  function automatic logic [7:0] seg_code(input logic [DISP_W-1:0] disp,
                                          input logic [3:0] digit,
                                          input logic [3:0] mask);
    logic [7:0] p;
    logic [3:0] d4;
    d4 = 4'(disp);
    p  = digit_pattern(digit);
    if (d4 < 4'd4 && mask[d4[1:0]]) begin
      p = ~p;
    end
    return p & PIN_MASK;
  endfunction

endpackage

// File: hw/rtl/b7s_front.sv
// ----------------------------------------------------------------------------
// b7s_front: request intake and classification
// Checks each request and turns it into a command for the back end.
// ----------------------------------------------------------------------------
module b7s_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_op,
  input  logic [3:0]    in_display_index,
  input  logic [15:0]   in_value,
  input  logic          fifo_full,
  output logic          push,
  output b7s_pkg::cmd_t push_cmd
);
  import b7s_pkg::*;

  // take a request whenever the queue has room
  assign in_ready = !fifo_full;
  assign push     = in_valid && !fifo_full;

  // classify the request
  always_comb begin
    push_cmd        = '0;
    push_cmd.kind   = KIND_SINGLE;
    push_cmd.status = ST_OK;
    if (op_t'(in_op) == OP_DIGIT) begin
      if (in_display_index > 4'(NUM_DIGITS - 1)) begin
        push_cmd.status = ST_BAD_INDEX;
      end else if (in_value > MAX_DIGIT) begin
        push_cmd.status = ST_BAD_VALUE;
      end else begin
        push_cmd.disp  = in_display_index[DISP_W-1:0];
        push_cmd.value = in_value;
        push_cmd.we    = 1'b1;
      end
    end else begin
      if (in_value == 16'd0) begin
        // zero number: status only, no display touched
        push_cmd.kind = KIND_SINGLE;
      end else if (32'(in_value) >= DEC_LIMIT) begin
        push_cmd.kind = KIND_OVERFLOW;
      end else begin
        push_cmd.kind  = KIND_NUMBER;
        push_cmd.value = in_value;
      end
    end
  end

endmodule

// File: hw/rtl/b7s_cmd_fifo.sv
// ----------------------------------------------------------------------------
// b7s_cmd_fifo: short command queue
// Decouples request intake from result generation.
// ----------------------------------------------------------------------------
module b7s_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  b7s_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output b7s_pkg::cmd_t pop_cmd,
  output logic          empty
);
  import b7s_pkg::*;

  cmd_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: hw/rtl/b7s_back.sv
// ----------------------------------------------------------------------------
// b7s_back: digit extraction and segment result generation
// Runs one command at a time, one result per cycle while the output is taken, into an output register.
// ----------------------------------------------------------------------------
module b7s_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [3:0]    cathode_mask,
  input  logic          fifo_empty,
  input  b7s_pkg::cmd_t fifo_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_target_display,
  output logic [7:0]    out_segments,
  output logic          out_write_enable,
  output logic [1:0]    out_status,
  output logic          out_last
);
  import b7s_pkg::*;

  // current command
  logic              busy_r, busy_nxt;
  kind_t             kind_r, kind_nxt;
  logic [DISP_W-1:0] disp_r, disp_nxt;
  logic [15:0]       val_r, val_nxt;
  logic              we_r, we_nxt;
  status_t           status_r, status_nxt;

  // output register
  logic              ovalid_r, ovalid_nxt;
  logic [1:0]        otarget_r, otarget_nxt;
  logic [7:0]        oseg_r, oseg_nxt;
  logic              owe_r, owe_nxt;
  logic [1:0]        ostatus_r, ostatus_nxt;
  logic              olast_r, olast_nxt;

  logic [31:0]       prod;
  logic [15:0]       quot;
  logic [3:0]        rem;
  logic              emit;

  // one decimal digit per step
  assign prod = 32'(val_r) * 32'(DIV10_MUL);
  assign quot = 16'(prod >> DIV10_SHIFT);
  assign rem  = 4'(val_r - ((quot << 3) + (quot << 1)));

  assign emit = busy_r && (!ovalid_r || out_ready);
  assign pop  = !busy_r && !fifo_empty;

  always_comb begin
    busy_nxt    = busy_r;
    kind_nxt    = kind_r;
    disp_nxt    = disp_r;
    val_nxt     = val_r;
    we_nxt      = we_r;
    status_nxt  = status_r;
    ovalid_nxt  = ovalid_r && !out_ready;
    otarget_nxt = otarget_r;
    oseg_nxt    = oseg_r;
    owe_nxt     = owe_r;
    ostatus_nxt = ostatus_r;
    olast_nxt   = olast_r;

    // fetch the next command
    if (pop) begin
      busy_nxt   = 1'b1;
      kind_nxt   = fifo_cmd.kind;
      disp_nxt   = fifo_cmd.disp;
      val_nxt    = fifo_cmd.value;
      we_nxt     = fifo_cmd.we;
      status_nxt = fifo_cmd.status;
    end

    // produce one result
    if (emit) begin
      ovalid_nxt  = 1'b1;
      otarget_nxt = 2'(disp_r);
      owe_nxt     = 1'b1;
      unique case (kind_r)
        KIND_SINGLE: begin
          oseg_nxt    = we_r ? seg_code(disp_r, val_r[3:0], cathode_mask) : 8'd0;
          owe_nxt     = we_r;
          ostatus_nxt = status_r;
          olast_nxt   = 1'b1;
          busy_nxt    = 1'b0;
        end
        KIND_NUMBER: begin
          oseg_nxt    = seg_code(disp_r, rem, cathode_mask);
          ostatus_nxt = ST_OK;
          olast_nxt   = (quot == 16'd0);
          busy_nxt    = (quot != 16'd0);
          val_nxt     = quot;
          disp_nxt    = disp_r + DISP_W'(1);
        end
        KIND_OVERFLOW: begin
          oseg_nxt    = seg_code(disp_r, 4'd0, cathode_mask);
          ostatus_nxt = ST_BAD_VALUE;
          olast_nxt   = (disp_r == DISP_W'(NUM_DIGITS - 1));
          busy_nxt    = (disp_r != DISP_W'(NUM_DIGITS - 1));
          disp_nxt    = disp_r + DISP_W'(1);
        end
        default: begin
          oseg_nxt    = 8'd0;
          owe_nxt     = 1'b0;
          ostatus_nxt = ST_OK;
          olast_nxt   = 1'b1;
          busy_nxt    = 1'b0;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    disp_r    <= disp_nxt;
    val_r     <= val_nxt;
    we_r      <= we_nxt;
    status_r  <= status_nxt;
    otarget_r <= otarget_nxt;
    oseg_r    <= oseg_nxt;
    owe_r     <= owe_nxt;
    ostatus_r <= ostatus_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_valid          = ovalid_r;
  assign out_target_display = otarget_r;
  assign out_segments       = oseg_r;
  assign out_write_enable   = owe_r;
  assign out_status         = ostatus_r;
  assign out_last           = olast_r;

endmodule

// File: hw/rtl/binary_to_seven_segment_digits.sv
// ----------------------------------------------------------------------------
// binary_to_seven_segment_digits: decimal digit writer for seven-segment
// displays. A request either sets one display to one digit or splits a 16-bit
// number into decimal digits, least significant first, one result per display.
// ----------------------------------------------------------------------------
// A single-digit request gives one result; a number request gives one result
// per decimal digit (one for zero, four with error status when the number has
// too many digits). The front end accepts a request into a two-entry command
// queue; the back end fetches a command into its registers and then builds
// one result per cycle while the output is taken, using its single
// divide-by-ten step. The output register holds each result until it is
// taken; the next one is built in the cycle the current one is taken, so
// results of one command can follow without a gap. cathode_mask inverts the
// pattern of each marked display and is written via cfg_we.
module binary_to_seven_segment_digits (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [3:0]  in_display_index,
  input  logic [15:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_target_display,
  output logic [7:0]  out_segments,
  output logic        out_write_enable,
  output logic [1:0]  out_status,
  output logic        out_last
);
  import b7s_pkg::*;

  logic [3:0] cathode_mask_r;
  logic       push, pop, fifo_full, fifo_empty;
  cmd_t       push_cmd, pop_cmd;

  // polarity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cathode_mask_r <= 4'd0;
    end else if (cfg_we) begin
      cathode_mask_r <= cfg_wdata;
    end
  end

  b7s_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_display_index (in_display_index),
    .in_value         (in_value),
    .fifo_full        (fifo_full),
    .push             (push),
    .push_cmd         (push_cmd)
  );

  b7s_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (fifo_empty)
  );

  b7s_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cathode_mask       (cathode_mask_r),
    .fifo_empty         (fifo_empty),
    .fifo_cmd           (pop_cmd),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_target_display (out_target_display),
    .out_segments       (out_segments),
    .out_write_enable   (out_write_enable),
    .out_status         (out_status),
    .out_last           (out_last)
  );

  // results that do not drive pins carry no display and no pattern
  a_idle_result_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |-> out_segments == 8'd0 && out_target_display == 2'd0)
    else $error("non-writing result carries display data");

  // a bad display index ends its request at once
  a_bad_index_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_BAD_INDEX |-> out_last && !out_write_enable)
    else $error("bad index result not a lone status result");

  // an ok result that writes nothing is the only result of a zero number
  a_zero_number_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK && !out_write_enable |-> out_last)
    else $error("status-only ok result not final");

  // queue never pops while empty nor pushes while full
  a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && fifo_empty) && !(push && fifo_full))
    else $error("command queue overrun or underrun");

endmodule
